/* hw/rtl/bhq_pkg.sv */
// bhq_pkg: shared types and constants for the binary max-heap queue
// used by bhq_cell and binary_max_heap_queue; no dependencies

package bhq_pkg;

    localparam int KEY_W   = 32;
    localparam int PATH_W  = 16;
    localparam int DEPTH_W = 5;

    // command codes on s_tuser
    typedef enum logic {
        CMD_INSERT  = 1'b0,
        CMD_EXTRACT = 1'b1
    } cmd_t;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    // work carried down the chain of level cells
    typedef enum logic [1:0] {
        OP_INSERT,
        OP_FETCH,
        OP_SIFT
    } op_t;

    // top level sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_WALK,
        ST_RESULT
    } state_t;

    // token handed from one level cell to the next
    // insert/fetch: path is the target index inside level depth
    // sift: path is the parent index one level up, sib the parent's sibling
    typedef struct packed {
        logic               vld;
        op_t                op;
        logic [PATH_W-1:0]  path;
        logic [DEPTH_W-1:0] depth;
        logic [KEY_W-1:0]   carry;
        logic [KEY_W-1:0]   sib;
    } token_t;

    // row write handed back to the level above (low half is the even slot)
    typedef struct packed {
        logic               vld;
        logic [PATH_W-1:0]  row;
        logic [2*KEY_W-1:0] data;
    } wb_t;

    // completion pulse from a cell
    typedef struct packed {
        logic             vld;
        logic [KEY_W-1:0] value;
    } done_t;

endpackage

/* hw/rtl/bhq_ram.sv */
// bhq_ram: generic single write port, single read port RAM with registered read
// no dependencies

module bhq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/bhq_cell.sv */
// bhq_cell: one tree level of the heap, stored as rows of sibling pairs
// depends on bhq_pkg and bhq_ram

module bhq_cell #(
    parameter int LEVEL   = 1,
    parameter bit IS_LAST = 1'b0,
    parameter int OW      = 11
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [OW-1:0]   occ,
    input  bhq_pkg::token_t in_tok,
    output bhq_pkg::token_t out_tok,
    output bhq_pkg::wb_t    up_wb,
    input  bhq_pkg::wb_t    dn_wb,
    output bhq_pkg::done_t  done
);

    localparam int DEPTH = 1 << (LEVEL - 1);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int GW    = LEVEL + 2;
    localparam int CW    = (GW > OW) ? GW : OW;
    localparam int KW    = bhq_pkg::KEY_W;
    localparam int PW    = bhq_pkg::PATH_W;
    localparam int DW    = bhq_pkg::DEPTH_W;

    logic            pend_reg;
    bhq_pkg::token_t tok_reg;

    logic [AW-1:0]   rd_addr;
    logic [2*KW-1:0] rd_data;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [2*KW-1:0] ram_wdata;
    logic            own_we;
    logic [AW-1:0]   own_addr;
    logic [2*KW-1:0] own_data;

    logic [DW-1:0]   in_shift;
    logic [PW-1:0]   in_idx;
    logic [PW-1:0]   in_row;

    logic [DW-1:0]   shift;
    logic [PW-1:0]   idx;
    logic [PW-1:0]   row;
    logic            half;
    logic [KW-1:0]   lo;
    logic [KW-1:0]   hi;
    logic [KW-1:0]   node;
    logic [CW-1:0]   gl;
    logic            vl;
    logic            vr;
    logic            sel_l;
    logic            sel_r;
    logic [KW-1:0]   big;

    // token capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= in_tok.vld;
        end
        if (in_tok.vld) begin
            tok_reg <= in_tok;
        end
    end

    // read address from the arriving token
    always_comb begin
        in_shift = in_tok.depth - DW'(LEVEL);
        in_idx   = in_tok.path >> in_shift;
        in_row   = (in_tok.op == bhq_pkg::OP_SIFT) ? in_tok.path : (in_idx >> 1);
        rd_addr  = in_row[AW-1:0];
    end

    // level storage, row r holds slots 2r and 2r+1
    bhq_ram #(
        .WIDTH(2 * KW),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(rd_addr),
        .rdata(rd_data)
    );

    // decision once the row is back
    always_comb begin
        shift = tok_reg.depth - DW'(LEVEL);
        idx   = tok_reg.path >> shift;
        row   = idx >> 1;
        half  = idx[0];
        lo    = rd_data[KW-1:0];
        hi    = rd_data[2*KW-1:KW];
        node  = half ? hi : lo;
        gl    = CW'((1 << LEVEL) - 1) + (CW'(tok_reg.path) << 1);
        vl    = gl < CW'(occ);
        vr    = (gl + CW'(1)) < CW'(occ);
        sel_l = vl && ($signed(lo) > $signed(tok_reg.carry));
        big   = sel_l ? lo : tok_reg.carry;
        sel_r = vr && ($signed(hi) > $signed(big));
        if (sel_r) begin
            big = hi;
        end

        out_tok  = '0;
        up_wb    = '0;
        done     = '0;
        own_we   = 1'b0;
        own_addr = row[AW-1:0];
        own_data = half ? {tok_reg.carry, lo} : {hi, tok_reg.carry};

        if (pend_reg) begin
            case (tok_reg.op)
                bhq_pkg::OP_INSERT: begin
                    if (tok_reg.depth == DW'(LEVEL)) begin
                        own_we   = 1'b1;
                        done.vld = 1'b1;
                    end else begin
                        out_tok     = tok_reg;
                        out_tok.vld = 1'b1;
                        if ($signed(tok_reg.carry) > $signed(node)) begin
                            own_we        = 1'b1;
                            out_tok.carry = node;
                        end
                    end
                end
                bhq_pkg::OP_FETCH: begin
                    if (tok_reg.depth == DW'(LEVEL)) begin
                        done.vld   = 1'b1;
                        done.value = node;
                    end else begin
                        out_tok     = tok_reg;
                        out_tok.vld = 1'b1;
                    end
                end
                bhq_pkg::OP_SIFT: begin
                    // parent slot takes the winner
                    up_wb.vld  = 1'b1;
                    up_wb.row  = tok_reg.path >> 1;
                    up_wb.data = tok_reg.path[0] ? {big, tok_reg.sib} : {tok_reg.sib, big};
                    if (!sel_l && !sel_r) begin
                        done.vld = 1'b1;
                    end else if (IS_LAST) begin
                        // no level below: the moved key settles here
                        own_we   = 1'b1;
                        own_addr = tok_reg.path[AW-1:0];
                        own_data = sel_r ? {tok_reg.carry, lo} : {hi, tok_reg.carry};
                        done.vld = 1'b1;
                    end else begin
                        out_tok      = tok_reg;
                        out_tok.vld  = 1'b1;
                        out_tok.path = {tok_reg.path[PW-2:0], sel_r};
                        out_tok.sib  = sel_r ? lo : hi;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // write port: row from the level below first, else own write
    always_comb begin
        if (dn_wb.vld) begin
            ram_we    = 1'b1;
            ram_waddr = dn_wb.row[AW-1:0];
            ram_wdata = dn_wb.data;
        end else begin
            ram_we    = own_we;
            ram_waddr = own_addr;
            ram_wdata = own_data;
        end
    end

endmodule

/* hw/rtl/binary_max_heap_queue.sv */
// binary_max_heap_queue: max-heap priority queue of signed 32-bit keys
// depends on bhq_pkg, bhq_cell and bhq_ram
//
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tuser: command, s_tdata: key
// m_       out  m_tvalid/m_tready  m_tdata: removed_key .. status
//
// the root lives in a register, every deeper level in one cell with its own RAM
// each level's row read starts as the token leaves the level above
// insert walks to depth D of the last slot, extract fetches it and then sifts down
// (D is at most 10 for 1024 entries); full insert or empty extract skips the walk
// reset clears the count, slot position and state; heap RAMs need no clearing pass
// a finished result waits in the output register while the next request is taken

module binary_max_heap_queue #(
    parameter int CAPACITY = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] key
    input  logic [0:0]  s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // [31:0] removed_key, [32] removed_valid,
                                   // [64:33] top_key, [75:65] entry_count,
                                   // [77:76] status, [79:78] zero
);

    localparam int LV = $clog2(CAPACITY + 1);
    localparam int NC = LV - 1;
    localparam int OW = LV;
    localparam int KW = bhq_pkg::KEY_W;
    localparam int PW = bhq_pkg::PATH_W;
    localparam int DW = bhq_pkg::DEPTH_W;

    bhq_pkg::state_t state_reg, state_next;
    logic [OW-1:0]   occ_reg, occ_next;
    logic [DW-1:0]   nd_reg, nd_next;
    logic [PW-1:0]   nj_reg, nj_next;
    logic [KW-1:0]   root_reg, root_next;
    bhq_pkg::token_t tok_reg, tok_next;
    logic [KW-1:0]   removed_reg, removed_next;
    logic            rvalid_reg, rvalid_next;
    bhq_pkg::status_t status_reg, status_next;
    logic            m_valid_reg, m_valid_next;
    logic [79:0]     m_data_reg, m_data_next;

    bhq_pkg::token_t tok [NC+1];
    bhq_pkg::wb_t    wb [NC+2];
    bhq_pkg::done_t  dn [NC+1];
    bhq_pkg::done_t  done_any;
    logic [NC-1:0]   done_vec;

    logic            accept;
    logic            cmd_ins;
    logic            m_load;
    logic [PW:0]     lvl_size;
    logic [DW-1:0]   dec_d;
    logic [PW-1:0]   dec_j;
    logic [KW-1:0]   top_key;
    logic [OW+10:0]  occ_wide;

    assign s_tready = (state_reg == bhq_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign cmd_ins  = (s_tuser[0] == bhq_pkg::CMD_INSERT);

    // chain of level cells
    assign tok[0]    = tok_reg;
    assign wb[NC+1]  = '0;
    assign dn[0]     = '0;

    for (genvar k = 1; k <= NC; k++) begin : g_cell
        bhq_cell #(
            .LEVEL  (k),
            .IS_LAST(k == NC),
            .OW     (OW)
        ) u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .occ    (occ_reg),
            .in_tok (tok[k-1]),
            .out_tok(tok[k]),
            .up_wb  (wb[k]),
            .dn_wb  (wb[k+1]),
            .done   (dn[k])
        );
        assign done_vec[k-1] = dn[k].vld;
    end

    // merge completion pulses, at most one at a time
    always_comb begin
        done_any = '0;
        for (int i = 1; i <= NC; i++) begin
            done_any.vld   = done_any.vld | dn[i].vld;
            done_any.value = done_any.value | (dn[i].vld ? dn[i].value : '0);
        end
    end

    // position of the last slot after a removal
    always_comb begin
        lvl_size = (PW+1)'(1) << nd_reg;
        if (nj_reg == '0) begin
            dec_d = nd_reg - DW'(1);
            dec_j = PW'(((PW+1)'(1) << dec_d) - (PW+1)'(1));
        end else begin
            dec_d = nd_reg;
            dec_j = nj_reg - PW'(1);
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bhq_pkg::ST_IDLE: begin
                if (accept) begin
                    if (cmd_ins) begin
                        if (occ_reg == OW'(CAPACITY) || occ_reg == '0) begin
                            state_next = bhq_pkg::ST_RESULT;
                        end else begin
                            state_next = bhq_pkg::ST_WALK;
                        end
                    end else if (occ_reg == '0 || occ_reg == OW'(1)) begin
                        state_next = bhq_pkg::ST_RESULT;
                    end else begin
                        state_next = bhq_pkg::ST_FETCH;
                    end
                end
            end
            bhq_pkg::ST_FETCH: begin
                if (done_any.vld) begin
                    state_next = bhq_pkg::ST_WALK;
                end
            end
            bhq_pkg::ST_WALK: begin
                if (done_any.vld) begin
                    state_next = bhq_pkg::ST_RESULT;
                end
            end
            bhq_pkg::ST_RESULT: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = bhq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bhq_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath: root, count, slot position and tokens
    always_comb begin
        occ_next     = occ_reg;
        nd_next      = nd_reg;
        nj_next      = nj_reg;
        root_next    = root_reg;
        tok_next     = '0;
        removed_next = removed_reg;
        rvalid_next  = rvalid_reg;
        status_next  = status_reg;

        if (wb[1].vld) begin
            root_next = wb[1].data[KW-1:0];
        end

        case (state_reg)
            bhq_pkg::ST_IDLE: begin
                if (accept) begin
                    removed_next = '0;
                    rvalid_next  = 1'b0;
                    status_next  = bhq_pkg::STAT_OK;
                    if (cmd_ins) begin
                        if (occ_reg == OW'(CAPACITY)) begin
                            status_next = bhq_pkg::STAT_FULL;
                        end else begin
                            occ_next = occ_reg + OW'(1);
                            if ((PW+1)'(nj_reg) + (PW+1)'(1) == lvl_size) begin
                                nd_next = nd_reg + DW'(1);
                                nj_next = '0;
                            end else begin
                                nj_next = nj_reg + PW'(1);
                            end
                            if (occ_reg == '0) begin
                                root_next = s_tdata;
                            end else begin
                                tok_next.vld   = 1'b1;
                                tok_next.op    = bhq_pkg::OP_INSERT;
                                tok_next.path  = nj_reg;
                                tok_next.depth = nd_reg;
                                if ($signed(s_tdata) > $signed(root_reg)) begin
                                    root_next      = s_tdata;
                                    tok_next.carry = root_reg;
                                end else begin
                                    tok_next.carry = s_tdata;
                                end
                            end
                        end
                    end else if (occ_reg == '0) begin
                        status_next = bhq_pkg::STAT_EMPTY;
                    end else begin
                        removed_next = root_reg;
                        rvalid_next  = 1'b1;
                        occ_next     = occ_reg - OW'(1);
                        nd_next      = dec_d;
                        nj_next      = dec_j;
                        if (occ_reg != OW'(1)) begin
                            tok_next.vld   = 1'b1;
                            tok_next.op    = bhq_pkg::OP_FETCH;
                            tok_next.path  = dec_j;
                            tok_next.depth = dec_d;
                        end
                    end
                end
            end
            bhq_pkg::ST_FETCH: begin
                // last key starts at the root and sinks
                if (done_any.vld) begin
                    tok_next.vld   = 1'b1;
                    tok_next.op    = bhq_pkg::OP_SIFT;
                    tok_next.carry = done_any.value;
                end
            end
            default: begin
            end
        endcase
    end

    // result register
    always_comb begin
        occ_wide     = {11'd0, occ_reg};
        top_key      = (occ_reg != '0) ? root_reg : '0;
        m_load       = (state_reg == bhq_pkg::ST_RESULT) && (!m_valid_reg || m_tready);
        m_valid_next = m_load || (m_valid_reg && !m_tready);
        m_data_next  = m_data_reg;
        if (m_load) begin
            m_data_next = {2'b00, status_reg, occ_wide[10:0], top_key, rvalid_reg, removed_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bhq_pkg::ST_IDLE;
            occ_reg     <= '0;
            nd_reg      <= '0;
            nj_reg      <= '0;
            tok_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            nd_reg      <= nd_next;
            nj_reg      <= nj_next;
            tok_reg     <= tok_next;
            m_valid_reg <= m_valid_next;
        end
        root_reg    <= root_next;
        removed_reg <= removed_next;
        rvalid_reg  <= rvalid_next;
        status_reg  <= status_next;
        m_data_reg  <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    a_root_wb_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        wb[1].vld |-> state_reg == bhq_pkg::ST_WALK)
        else $error("root written back outside a sift");
    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_any.vld |-> (state_reg == bhq_pkg::ST_FETCH || state_reg == bhq_pkg::ST_WALK))
        else $error("cell completion while sequencer not waiting");
    a_done_single: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(done_vec))
        else $error("more than one cell completed at once");
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OW'(CAPACITY))
        else $error("count above capacity");
    a_last_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        !tok[NC].vld)
        else $error("token left the deepest level");
`endif

endmodule
